// ===== rtl/obef_pkg.sv =====
package obef_pkg;

    localparam int NUM_REGS   = 6;
    localparam int REG_IDX_W  = 3;
    localparam int ROW_W      = 48;
    localparam int COEF_W     = 16;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 31;
    localparam int PROD_W     = COEF_W + DATA_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 14;
    localparam int SHIFTED_W  = ACC_W - FRAC_SHIFT;
    localparam int LANES      = 3;
    localparam int LANE_W     = 2;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_INV_ROW0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXES_ROW0 = 3'd3;

    // Two identity matrices, one row per register.
    localparam logic [ROW_W-1:0] REG_RESET [NUM_REGS] = '{
        48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
        48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MAP_WAIT,
        ST_UPDATE,
        ST_CENTER,
        ST_CENTER_WAIT,
        ST_EMIT
    } obef_state_t;

    // Control travelling alongside each row through the dot-product unit.
    typedef struct packed {
        logic              valid;
        logic [LANE_W-1:0] lane;
    } dot_ctl_t;

endpackage

// ===== rtl/obef_dot_unit.sv =====
module obef_dot_unit
    import obef_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dot_ctl_t                 req,
    input  logic [ROW_W-1:0]         row,
    input  logic signed [DATA_W-1:0] vec [LANES],
    output dot_ctl_t                 rsp,
    output logic signed [DATA_W-1:0] result
);

    logic signed [COEF_W-1:0]    coef      [LANES];
    logic signed [PROD_W-1:0]    prod_next [LANES];
    logic signed [PROD_W-1:0]    prod_reg  [LANES];
    dot_ctl_t                    ctl1_reg;
    dot_ctl_t                    ctl2_reg;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SHIFTED_W-1:0] shifted;
    logic signed [DATA_W-1:0]    result_next;
    logic signed [DATA_W-1:0]    result_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            coef[k]      = signed'(row[COEF_W*k +: COEF_W]);
            prod_next[k] = PROD_W'(coef[k]) * PROD_W'(vec[k]);
        end
    end

    // Exact sum, round half up, then clamp to the signed 32-bit range.
    always_comb
    begin
        acc = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2])
            + ACC_W'(1 << (FRAC_SHIFT - 1));
        shifted = SHIFTED_W'(acc >>> FRAC_SHIFT);
        if (shifted[SHIFTED_W-1:DATA_W-1] == '0 || shifted[SHIFTED_W-1:DATA_W-1] == '1)
        begin
            result_next = shifted[DATA_W-1:0];
        end
        else if (shifted[SHIFTED_W-1])
        begin
            result_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            result_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= req;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANES; k++)
        begin
            prod_reg[k] <= prod_next[k];
        end
        result_reg <= result_next;
    end

    assign rsp    = ctl2_reg;
    assign result = result_reg;

    a_dot_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> ##2 (rsp.valid && rsp.lane == $past(req.lane, 2)))
        else $error("dot unit lost or reordered a row");

endmodule

// ===== rtl/obef_track.sv =====
module obef_track
    import obef_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     update,
    input  logic                     clear,
    input  logic signed [DATA_W-1:0] q      [LANES],
    output logic [LEN_W-1:0]         length [LANES],
    output logic signed [DATA_W-1:0] mid    [LANES]
);

    logic signed [DATA_W-1:0] low_reg  [LANES];
    logic signed [DATA_W-1:0] high_reg [LANES];
    logic signed [DATA_W-1:0] low_next  [LANES];
    logic signed [DATA_W-1:0] high_next [LANES];
    logic                     first_pending_reg;
    logic                     first_pending_next;
    logic signed [DATA_W:0]   diff [LANES];
    logic signed [DATA_W:0]   sum  [LANES];

    always_comb
    begin
        first_pending_next = first_pending_reg;
        for (int k = 0; k < LANES; k++)
        begin
            low_next[k]  = low_reg[k];
            high_next[k] = high_reg[k];
        end
        if (clear)
        begin
            first_pending_next = 1'b1;
            for (int k = 0; k < LANES; k++)
            begin
                low_next[k]  = '0;
                high_next[k] = '0;
            end
        end
        else if (update)
        begin
            first_pending_next = 1'b0;
            for (int k = 0; k < LANES; k++)
            begin
                if (first_pending_reg || q[k] < low_reg[k])
                begin
                    low_next[k] = q[k];
                end
                if (first_pending_reg || q[k] > high_reg[k])
                begin
                    high_next[k] = q[k];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            diff[k] = (DATA_W+1)'(high_reg[k]) - (DATA_W+1)'(low_reg[k]);
            sum[k]  = (DATA_W+1)'(high_reg[k]) + (DATA_W+1)'(low_reg[k]);
            if (diff[k][DATA_W])
            begin
                length[k] = '0;
            end
            else if (diff[k][DATA_W-1])
            begin
                length[k] = '1;
            end
            else
            begin
                length[k] = diff[k][LEN_W-1:0];
            end
            // Dropping the low bit of the exact sum halves it with flooring.
            mid[k] = sum[k][DATA_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
            for (int k = 0; k < LANES; k++)
            begin
                low_reg[k]  <= '0;
                high_reg[k] <= '0;
            end
        end
        else
        begin
            first_pending_reg <= first_pending_next;
            for (int k = 0; k < LANES; k++)
            begin
                low_reg[k]  <= low_next[k];
                high_reg[k] <= high_next[k];
            end
        end
    end

    a_clear_arms_first: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> first_pending_reg)
        else $error("tracker not rearmed after clear");

    a_update_orders: assert property (@(posedge clk) disable iff (!rst_n)
        (update && !clear) |=> (low_reg[0] <= high_reg[0] && low_reg[1] <= high_reg[1]
                                && low_reg[2] <= high_reg[2]))
        else $error("tracked minimum exceeds maximum");

endmodule

// ===== rtl/oriented_box_extent_fit.sv =====
// A point holds the block from acceptance until it is ready again; one marked last also
// holds it for the center and output steps, and longer while an earlier word waits for
// m_tready. The result word turns valid in the cycle that the block is ready again. Each
// row passes the product and result registers of the shared three-multiplier unit: three
// rows map a point, three more form the center, plus one update step and one output step.
// Reset (rst_n, asynchronous, active low) loads identity matrices and clears the extents.
module oriented_box_extent_fit
    import obef_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // point_x, point_y, point_z
    input  logic                 s_tlast,   // last_point
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [191:0]         m_tdata,   // length_x, length_y, length_z,
                                            // center_x, center_y, center_z, zero fill
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data
);

    obef_state_t              state_reg, state_next;
    logic [LANE_W-1:0]        cnt_reg, cnt_next;
    logic                     last_reg;
    logic signed [DATA_W-1:0] point_reg [LANES];
    logic signed [DATA_W-1:0] res_reg   [LANES];
    logic [ROW_W-1:0]         regs_reg  [NUM_REGS];
    logic [REG_IDX_W-1:0]     row_idx;
    dot_ctl_t                 req;
    dot_ctl_t                 rsp;
    logic signed [DATA_W-1:0] dot_result;
    logic signed [DATA_W-1:0] dot_vec [LANES];
    logic signed [DATA_W-1:0] mid     [LANES];
    logic [LEN_W-1:0]         length  [LANES];
    logic                     track_update;
    logic                     track_clear;
    logic                     out_load;
    logic                     out_valid_reg;
    logic [LEN_W-1:0]         out_len_reg [LANES];
    logic signed [DATA_W-1:0] out_ctr_reg [LANES];
    logic                     accept;
    logic                     center_phase;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_index < REG_IDX_W'(NUM_REGS))
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    assign center_phase = (state_reg == ST_CENTER);
    assign row_idx      = (center_phase ? REG_AXES_ROW0 : REG_INV_ROW0) + REG_IDX_W'(cnt_reg);

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            dot_vec[k] = center_phase ? mid[k] : point_reg[k];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        req          = '0;
        track_update = 1'b0;
        track_clear  = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP, ST_CENTER:
            begin
                req.valid = 1'b1;
                req.lane  = cnt_reg;
                if (cnt_reg == LANE_W'(LANES - 1))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_MAP) ? ST_MAP_WAIT : ST_CENTER_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAP_WAIT:
            begin
                if (rsp.valid && rsp.lane == LANE_W'(LANES - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                track_update = 1'b1;
                state_next   = last_reg ? ST_CENTER : ST_IDLE;
            end
            ST_CENTER_WAIT:
            begin
                if (rsp.valid && rsp.lane == LANE_W'(LANES - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load    = 1'b1;
                    track_clear = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= s_tlast;
            for (int k = 0; k < LANES; k++)
            begin
                point_reg[k] <= s_tdata[DATA_W*k +: DATA_W];
            end
        end
        if (rsp.valid)
        begin
            res_reg[rsp.lane] <= dot_result;
        end
        if (out_load)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                out_len_reg[k] <= length[k];
                out_ctr_reg[k] <= res_reg[k];
            end
        end
    end

    obef_dot_unit u_dot (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .row    (regs_reg[row_idx]),
        .vec    (dot_vec),
        .rsp    (rsp),
        .result (dot_result)
    );

    obef_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (track_update),
        .clear  (track_clear),
        .q      (res_reg),
        .length (length),
        .mid    (mid)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_ctr_reg[2], out_ctr_reg[1], out_ctr_reg[0],
                       out_len_reg[2], out_len_reg[1], out_len_reg[0]};

    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (state_reg != ST_IDLE && state_reg != ST_UPDATE))
        else $error("dot result arrived with no row in flight");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("output word loaded outside the emit step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_len_reg[0]) && $stable(out_ctr_reg[0]))
        else $error("pending output word overwritten");

endmodule

// ===== dv/tb_oriented_box_extent_fit.sv =====
`timescale 1ns / 100ps

module tb_oriented_box_extent_fit;
    import obef_pkg::*;

    // A closing point keeps the block busy through its center and output steps; leave a margin.
    localparam int SLACK_CYCLES = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 26;
    localparam int RANDOM_ITEMS = 900;
    localparam int REPORT_MAX   = 10;

    localparam longint Q_MAX = 64'sh7FFF_FFFF;
    localparam longint Q_MIN = -64'sh8000_0000;

    // Result word layout; the packed struct lists the highest field first.
    typedef struct packed {
        logic [DATA_W-1:0] center_z;
        logic [DATA_W-1:0] center_y;
        logic [DATA_W-1:0] center_x;
        logic [LEN_W-1:0]  length_z;
        logic [LEN_W-1:0]  length_y;
        logic [LEN_W-1:0]  length_x;
    } box_word_t;

    typedef enum int {
        ROW_IDENT,
        ROW_SMALL,
        ROW_FULL,
        ROW_MAX,
        ROW_MIN,
        ROW_ZERO,
        ROW_ONES
    } row_style_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [191:0]         m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_data  = '0;

    // Shadow copy of the matrices and of the running box in its own frame.
    logic [ROW_W-1:0] matrix_rows [NUM_REGS];
    longint           box_low [LANES];
    longint           box_high [LANES];
    bit               cloud_empty;
    box_word_t        expected_boxes [$];

    int mismatches   = 0;
    bit quiet_sides  = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;

    oriented_box_extent_fit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_q16(longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // Q2.14 row times Q16.16 vector, rounded half up, saturated to Q16.16.
    function automatic longint row_dot(logic [ROW_W-1:0] row, longint a, longint b, longint c);
        longint coef [LANES];
        longint acc;
        for (int k = 0; k < LANES; k++)
            coef[k] = longint'($signed(row[k*COEF_W +: COEF_W]));
        acc = coef[0] * a + coef[1] * b + coef[2] * c + (longint'(1) << (FRAC_SHIFT - 1));
        return clamp_q16(acc >>> FRAC_SHIFT);
    endfunction

    function automatic logic [LEN_W-1:0] extent_of(longint hi, longint lo);
        longint d;
        d = hi - lo;
        if (d < 0)
            d = 0;
        if (d > Q_MAX)
            d = Q_MAX;
        return d[LEN_W-1:0];
    endfunction

    function automatic void clear_box();
        for (int i = 0; i < LANES; i++)
        begin
            box_low[i]  = 0;
            box_high[i] = 0;
        end
        cloud_empty = 1'b1;
    endfunction

    function automatic void fit_point(logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
                                      logic signed [DATA_W-1:0] pz, logic closes);
        longint    mapped [LANES];
        longint    mid [LANES];
        box_word_t box;
        for (int i = 0; i < LANES; i++)
            mapped[i] = row_dot(matrix_rows[REG_INV_ROW0 + i], px, py, pz);
        for (int i = 0; i < LANES; i++)
        begin
            if (cloud_empty || mapped[i] < box_low[i])
                box_low[i] = mapped[i];
            if (cloud_empty || mapped[i] > box_high[i])
                box_high[i] = mapped[i];
        end
        cloud_empty = 1'b0;
        if (closes)
        begin
            for (int i = 0; i < LANES; i++)
                mid[i] = (box_high[i] + box_low[i]) >>> 1;
            box.length_x = extent_of(box_high[0], box_low[0]);
            box.length_y = extent_of(box_high[1], box_low[1]);
            box.length_z = extent_of(box_high[2], box_low[2]);
            box.center_x = DATA_W'(row_dot(matrix_rows[REG_AXES_ROW0], mid[0], mid[1], mid[2]));
            box.center_y = DATA_W'(row_dot(matrix_rows[REG_AXES_ROW0 + 1], mid[0], mid[1], mid[2]));
            box.center_z = DATA_W'(row_dot(matrix_rows[REG_AXES_ROW0 + 2], mid[0], mid[1], mid[2]));
            expected_boxes.push_back(box);
            clear_box();
        end
    endfunction

    function automatic void note_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%t: %s", $realtime, msg);
    endfunction

    function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        if (want !== got)
            note_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endfunction

    function automatic logic [ROW_W-1:0] make_row(row_style_t style, int r);
        logic [COEF_W-1:0] c [LANES];
        case (style)
            ROW_IDENT: return REG_RESET[r];
            ROW_MAX:   return {LANES{16'h7FFF}};
            ROW_MIN:   return {LANES{16'h8000}};
            ROW_ZERO:  return '0;
            ROW_ONES:  return '1;
            ROW_FULL:  return {16'($urandom), $urandom};
            default:
            begin
                for (int k = 0; k < LANES; k++)
                    c[k] = 16'($urandom_range(0, 32768)) - 16'd16384;
                return {c[2], c[1], c[0]};
            end
        endcase
    endfunction

    function automatic row_style_t pick_style();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return ROW_SMALL;
        if (pick < 70)
            return ROW_FULL;
        if (pick < 76)
            return ROW_IDENT;
        if (pick < 82)
            return ROW_MAX;
        if (pick < 88)
            return ROW_MIN;
        if (pick < 94)
            return ROW_ZERO;
        return ROW_ONES;
    endfunction

    function automatic logic [DATA_W-1:0] rand_coord();
        int         pick;
        logic [19:0] near;
        pick = $urandom_range(99);
        near = 20'($urandom);
        if (pick < 45)
            return $urandom;
        if (pick < 85)
            return {{12{near[19]}}, near};
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic send_point(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                              logic [DATA_W-1:0] pz, logic closes);
        @(negedge clk);
        if (!quiet_sides)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        s_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_tready);
        fit_point(px, py, pz, closes);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_REGS)
            matrix_rows[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_rows(row_style_t inv_style, row_style_t axes_style, bit mixed);
        for (int i = 0; i < LANES; i++)
            write_reg(REG_IDX_W'(REG_INV_ROW0 + i),
                      make_row(mixed ? pick_style() : inv_style, i));
        for (int i = 0; i < LANES; i++)
            write_reg(REG_IDX_W'(REG_AXES_ROW0 + i),
                      make_row(mixed ? pick_style() : axes_style, LANES + i));
    endtask

    // Drain the block so that the configuration may change safely.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (SLACK_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_identity();
        // A lone point is its own box: zero extents, centered on itself.
        send_point(32'h0001_8000, 32'hFFFE_0000, 32'h0000_0000, 1'b1);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_point(32'hFFFF_0000, 32'h0005_0000, 32'h0000_4000, 1'b0);
        send_point(32'h0000_0000, 32'hFFF0_0000, 32'h0010_0000, 1'b1);
        // Opposite corners of the range overflow the extent.
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        // An odd negative sum exercises the floor in the midpoint.
        send_point(32'hFFFF_FFFD, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        settle();
    endtask

    task automatic test_coefficient_extremes();
        load_rows(ROW_MAX, ROW_MIN, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h0000_2000, 32'hFFFF_E000, 32'h0000_0001, 1'b1);
        settle();
        load_rows(ROW_MIN, ROW_MAX, 1'b0);
        send_point(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0000, 1'b1);
        settle();
        load_rows(ROW_ZERO, ROW_ONES, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
        settle();
        load_rows(ROW_ONES, ROW_ZERO, 1'b0);
        send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        settle();
    endtask

    task automatic test_unused_index();
        load_rows(ROW_SMALL, ROW_SMALL, 1'b0);
        // Writes past the last register must leave the matrices alone.
        write_reg(REG_IDX_W'(NUM_REGS), {16'($urandom), $urandom});
        write_reg(REG_IDX_W'(NUM_REGS + 1), {16'($urandom), $urandom});
        send_point(32'h0004_0000, 32'hFFFC_0000, 32'h0002_0000, 1'b0);
        send_point(32'hFFF8_0000, 32'h0008_0000, 32'hFFFE_0000, 1'b1);
        settle();
    endtask

    task automatic test_random_clouds(int budget);
        int sent;
        int phase;
        int in_phase;
        int cloud;
        sent  = 0;
        phase = 0;
        while (sent < budget)
        begin
            if (phase == 0)
                load_rows(ROW_FULL, ROW_FULL, 1'b0);
            else if (phase == 1)
                load_rows(ROW_IDENT, ROW_IDENT, 1'b0);
            else
                load_rows(ROW_SMALL, ROW_SMALL, 1'b1);
            quiet_sides = (phase == 3);
            in_phase    = 0;
            while (in_phase < 110)
            begin
                cloud = ($urandom_range(99) < 8) ? $urandom_range(20, 40) : $urandom_range(1, 10);
                for (int j = 0; j < cloud; j++)
                    send_point(rand_coord(), rand_coord(), rand_coord(), j == cloud - 1);
                in_phase += cloud;
            end
            sent += in_phase;
            quiet_sides = 1'b0;
            settle();
            phase++;
        end
    endtask

    task automatic test_backpressure();
        int cloud;
        load_rows(ROW_SMALL, ROW_SMALL, 1'b1);
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
        begin
            cloud = $urandom_range(1, 2);
            for (int j = 0; j < cloud; j++)
                send_point(rand_coord(), rand_coord(), rand_coord(), j == cloud - 1);
        end
        settle();
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet_sides || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : check_results
        box_word_t want;
        box_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(box_word_t)-1:0];
            if (expected_boxes.size() == 0)
                note_error($sformatf("result word with no box pending: %h", m_tdata));
            else
            begin
                want = expected_boxes.pop_front();
                compare_field("length_x", want.length_x, got.length_x);
                compare_field("length_y", want.length_y, got.length_y);
                compare_field("length_z", want.length_z, got.length_z);
                compare_field("center_x", want.center_x, got.center_x);
                compare_field("center_y", want.center_y, got.center_y);
                compare_field("center_z", want.center_z, got.center_z);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("oriented_box_extent_fit verification failed");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < NUM_REGS; r++)
            matrix_rows[r] = REG_RESET[r];
        clear_box();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_identity();
        test_coefficient_extremes();
        test_unused_index();
        test_random_clouds(RANDOM_ITEMS);
        test_backpressure();

        settle();
        if (expected_boxes.size() != 0)
            note_error($sformatf("%0d boxes never arrived", expected_boxes.size()));
        if (mismatches == 0)
            $display("oriented_box_extent_fit verification clean");
        else
            $display("oriented_box_extent_fit verification failed");
        $finish;
    end

endmodule
